// ===== rtl/vfv_pkg.sv =====
package vfv_pkg;

    // Interior edge of the cube and width of the opacity code in use
    localparam int GRID_EDGE    = 16;
    localparam int OPACITY_BITS = 8;

    localparam int PAD_EDGE    = GRID_EDGE + 2;
    localparam int LAYER_CELLS = PAD_EDGE * PAD_EDGE;
    localparam int WIN_DEPTH   = 2 * LAYER_CELLS + 1;
    localparam int COORD_W     = $clog2(PAD_EDGE);

    // Window taps, counted in beats back from the newest cell
    localparam int TAP_TOP    = 0;
    localparam int TAP_FRONT  = LAYER_CELLS - PAD_EDGE;
    localparam int TAP_RIGHT  = LAYER_CELLS - 1;
    localparam int TAP_SELF   = LAYER_CELLS;
    localparam int TAP_LEFT   = LAYER_CELLS + 1;
    localparam int TAP_BACK   = LAYER_CELLS + PAD_EDGE;
    localparam int TAP_BOTTOM = 2 * LAYER_CELLS;

    // Window split: line buffer up to the front tap, short shift line up to
    // the right tap, self and left cells, short shift line up to the back
    // tap, line buffer up to the bottom tap
    localparam int LINE_A_DEPTH = TAP_FRONT;
    localparam int NEAR_LEN     = TAP_RIGHT - TAP_FRONT;
    localparam int FAR_LEN      = TAP_BACK - TAP_LEFT;
    localparam int LINE_B_DEPTH = TAP_BOTTOM - TAP_BACK - 1;
    localparam int LINE_A_AW    = $clog2(LINE_A_DEPTH);
    localparam int LINE_B_AW    = $clog2(LINE_B_DEPTH);

    typedef logic [OPACITY_BITS-1:0] code_t;
    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic [LINE_A_AW-1:0]    line_a_addr_t;
    typedef logic [LINE_B_AW-1:0]    line_b_addr_t;

    typedef struct packed {
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [3:0] cell_z;
        logic       last;
    } cell_info_t;

    typedef struct packed {
        code_t self_code;
        code_t top_code;
        code_t bottom_code;
        code_t left_code;
        code_t right_code;
        code_t front_code;
        code_t back_code;
    } hood_t;

endpackage

// ===== rtl/voxel_face_visibility_unit.sv =====
// Channel  | handshake           | payload
// ---------+---------------------+------------------------------------------
// input    | in_valid, in_ready  | opacity_code[7:0], grid_start
// output   | out_valid, out_ready| cell_x, cell_y, cell_z, face_*, last_cell
//
// One padded cell is taken per cycle while the decode stage is not stalled; a
// judged interior cell passes decode, tap capture and compare after the beat
// that completes its neighbourhood, one result per cycle while out_ready holds.
// Reset clears the position counters, line buffer pointers and stage valid
// bits; the window holds garbage until the current grid has filled it.
// An output stall holds the full stages back to the first empty one; in_ready
// falls only when the decode stage holds a beat that cannot advance.
module voxel_face_visibility_unit
    import vfv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] opacity_code,
    input  logic       grid_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] cell_x,
    output logic [3:0] cell_y,
    output logic [3:0] cell_z,
    output logic       face_top,
    output logic       face_bottom,
    output logic       face_left,
    output logic       face_right,
    output logic       face_front,
    output logic       face_back,
    output logic       last_cell
);

    // Padded position of the next cell, as layer / row / column counters
    coord_t lay_reg, lay_next;
    coord_t row_reg, row_next;
    coord_t col_reg, col_next;

    coord_t lay_cur, row_cur, col_cur;
    logic   in_beat;
    logic   judge;
    code_t  code_in;

    // Window of the last two padded layers plus one cell, kept as a delay
    // line: every tap register holds the cell that many beats behind the
    // newest one. The two long stretches live in circular line buffers.
    code_t        top_tap_reg;
    code_t        front_tap_reg;
    code_t        near_reg [NEAR_LEN];
    code_t        self_tap_reg;
    code_t        left_tap_reg;
    code_t        far_reg [FAR_LEN];
    code_t        bottom_tap_reg;
    code_t        line_a_mem [LINE_A_DEPTH];
    code_t        line_b_mem [LINE_B_DEPTH];
    line_a_addr_t line_a_ptr_reg, line_a_ptr_next;
    line_b_addr_t line_b_ptr_reg, line_b_ptr_next;

    // Stage valid bits and payload
    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    cell_info_t s1_info_reg, s2_info_reg, s3_info_reg;
    cell_info_t s1_info_next;
    hood_t      s2_hood_reg;
    logic [5:0] s3_face_reg, s3_face_next;

    logic en1, en2, en3;

    // Each stage may load when it is empty or its content moves on
    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign in_beat  = in_valid && in_ready;

    assign code_in = code_t'(opacity_code);

    // Decode the position of the incoming cell. The judged cell sits one
    // layer behind, so its layer is lay_cur - 1 and must be interior.
    always_comb
    begin
        lay_cur = grid_start ? '0 : lay_reg;
        row_cur = grid_start ? '0 : row_reg;
        col_cur = grid_start ? '0 : col_reg;

        lay_next = lay_cur;
        row_next = row_cur;
        col_next = col_cur;
        if (col_cur == coord_t'(PAD_EDGE - 1))
        begin
            col_next = '0;
            if (row_cur == coord_t'(PAD_EDGE - 1))
            begin
                row_next = '0;
                // wrap after the last padded cell: a new grid follows
                lay_next = (lay_cur == coord_t'(PAD_EDGE - 1)) ? '0 : lay_cur + 1'b1;
            end
            else
            begin
                row_next = row_cur + 1'b1;
            end
        end
        else
        begin
            col_next = col_cur + 1'b1;
        end

        judge = (lay_cur >= coord_t'(2)) && (lay_cur <= coord_t'(GRID_EDGE + 1)) &&
                (row_cur >= coord_t'(1)) && (row_cur <= coord_t'(GRID_EDGE)) &&
                (col_cur >= coord_t'(1)) && (col_cur <= coord_t'(GRID_EDGE));

        s1_info_next.cell_x = 4'(row_cur - coord_t'(1));
        s1_info_next.cell_y = 4'(lay_cur - coord_t'(2));
        s1_info_next.cell_z = 4'(col_cur - coord_t'(1));
        s1_info_next.last   = (lay_cur == coord_t'(GRID_EDGE + 1)) &&
                              (row_cur == coord_t'(GRID_EDGE)) &&
                              (col_cur == coord_t'(GRID_EDGE));
    end

    // Line buffer pointers walk round their depth once per that many beats
    assign line_a_ptr_next = (line_a_ptr_reg == line_a_addr_t'(LINE_A_DEPTH - 1)) ?
                             '0 : line_a_ptr_reg + 1'b1;
    assign line_b_ptr_next = (line_b_ptr_reg == line_b_addr_t'(LINE_B_DEPTH - 1)) ?
                             '0 : line_b_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lay_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            line_a_ptr_reg <= '0;
            line_b_ptr_reg <= '0;
        end
        else if (in_beat)
        begin
            lay_reg        <= lay_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            line_a_ptr_reg <= line_a_ptr_next;
            line_b_ptr_reg <= line_b_ptr_next;
        end
    end

    // Line buffer A: the slot read back was written one full depth of beats
    // ago, which puts its output on the front tap
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            line_a_mem[line_a_ptr_reg] <= code_in;
            front_tap_reg              <= line_a_mem[line_a_ptr_reg];
        end
    end

    // Line buffer B: fed from the back tap, its output lands on the bottom tap
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            line_b_mem[line_b_ptr_reg] <= far_reg[FAR_LEN-1];
            bottom_tap_reg             <= line_b_mem[line_b_ptr_reg];
        end
    end

    // Advance the short shift lines on every accepted beat, border cells included
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            top_tap_reg <= code_in;
            near_reg[0] <= front_tap_reg;
            for (int i = 1; i < NEAR_LEN; i++)
            begin
                near_reg[i] <= near_reg[i-1];
            end
            self_tap_reg <= near_reg[NEAR_LEN-1];
            left_tap_reg <= self_tap_reg;
            far_reg[0]   <= left_tap_reg;
            for (int i = 1; i < FAR_LEN; i++)
            begin
                far_reg[i] <= far_reg[i-1];
            end
        end
    end

    // Compare each neighbour against the cell itself
    always_comb
    begin
        s3_face_next[5] = s2_hood_reg.top_code    < s2_hood_reg.self_code;
        s3_face_next[4] = s2_hood_reg.bottom_code < s2_hood_reg.self_code;
        s3_face_next[3] = s2_hood_reg.left_code   < s2_hood_reg.self_code;
        s3_face_next[2] = s2_hood_reg.right_code  < s2_hood_reg.self_code;
        s3_face_next[1] = s2_hood_reg.front_code  < s2_hood_reg.self_code;
        s3_face_next[0] = s2_hood_reg.back_code   < s2_hood_reg.self_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            // drop border cells here: only judged beats enter the pipe
            if (en1)
            begin
                s1_valid_reg <= in_beat && judge;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1 moves whenever a new beat shifts the window, so the taps
    // captured here still belong to the beat held in stage 1
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_info_reg <= s1_info_next;
        end
        if (en2)
        begin
            s2_info_reg             <= s1_info_reg;
            s2_hood_reg.self_code   <= self_tap_reg;
            s2_hood_reg.top_code    <= top_tap_reg;
            s2_hood_reg.bottom_code <= bottom_tap_reg;
            s2_hood_reg.left_code   <= left_tap_reg;
            s2_hood_reg.right_code  <= near_reg[NEAR_LEN-1];
            s2_hood_reg.front_code  <= front_tap_reg;
            s2_hood_reg.back_code   <= far_reg[FAR_LEN-1];
        end
        if (en3)
        begin
            s3_info_reg <= s2_info_reg;
            s3_face_reg <= s3_face_next;
        end
    end

    assign out_valid   = s3_valid_reg;
    assign cell_x      = s3_info_reg.cell_x;
    assign cell_y      = s3_info_reg.cell_y;
    assign cell_z      = s3_info_reg.cell_z;
    assign last_cell   = s3_info_reg.last;
    assign face_top    = s3_face_reg[5];
    assign face_bottom = s3_face_reg[4];
    assign face_left   = s3_face_reg[3];
    assign face_right  = s3_face_reg[2];
    assign face_front  = s3_face_reg[1];
    assign face_back   = s3_face_reg[0];

    // A grid start puts the next cell at padded position one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && grid_start |=>
            col_reg == coord_t'(1) && row_reg == '0 && lay_reg == '0)
        else $error("position not restarted by grid_start");

    // Input is held back only by a full decode stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && !en2)
        else $error("in_ready low without a stalled decode stage");

    // A stalled decode stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !en2 |=> s1_valid_reg)
        else $error("decode stage lost a beat");

    // A fully transparent cell shows no face
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && en3 && s2_hood_reg.self_code == '0 |=>
            out_valid && !face_top && !face_bottom && !face_left &&
            !face_right && !face_front && !face_back)
        else $error("transparent cell reported a visible face");

endmodule

// ===== tb/sv/voxel_face_visibility_checker.sv =====
`timescale 1ns / 100ps

module voxel_face_visibility_checker
    import vfv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] opacity_code,
    input  logic       grid_start,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] cell_x,
    input  logic [3:0] cell_y,
    input  logic [3:0] cell_z,
    input  logic       face_top,
    input  logic       face_bottom,
    input  logic       face_left,
    input  logic       face_right,
    input  logic       face_front,
    input  logic       face_back,
    input  logic       last_cell,
    output int         fail_count,
    output int         pending
);

    localparam int GRID_CELLS = PAD_EDGE * LAYER_CELLS;

    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
        logic       top;
        logic       bottom;
        logic       left;
        logic       right;
        logic       front;
        logic       back;
        logic       last;
    } face_mask_t;

    code_t       opacity_window [WIN_DEPTH];
    int unsigned next_cell_pos;
    face_mask_t  due_masks [$];

    initial
    begin
        foreach (opacity_window[i])
            opacity_window[i] = '0;
    end

    // Code of the cell that arrived 'back' beats before the one at 'pos'
    function automatic code_t window_tap(int unsigned pos, int unsigned back);
        return opacity_window[(pos % WIN_DEPTH + WIN_DEPTH - back) % WIN_DEPTH];
    endfunction

    function automatic bit is_inner(int unsigned c);
        return c >= 1 && c <= GRID_EDGE;
    endfunction

    // Store one padded cell; queue the face mask of the cell it completes
    task automatic absorb_cell(code_t code, logic start);
        int unsigned pos;
        int unsigned p;
        int unsigned lay;
        int unsigned row;
        int unsigned col;
        code_t       self_code;
        face_mask_t  m;
        pos = start ? 0 : next_cell_pos;
        if (pos >= GRID_CELLS)
            pos = 0;
        opacity_window[pos % WIN_DEPTH] = code;
        next_cell_pos = (pos + 1 >= GRID_CELLS) ? 0 : pos + 1;
        if (pos < LAYER_CELLS)
            return;
        p   = pos - LAYER_CELLS;
        lay = p / LAYER_CELLS;
        row = (p / PAD_EDGE) % PAD_EDGE;
        col = p % PAD_EDGE;
        if (!is_inner(lay) || !is_inner(row) || !is_inner(col))
            return;
        self_code = window_tap(pos, TAP_SELF);
        m.x      = 4'(row - 1);
        m.y      = 4'(lay - 1);
        m.z      = 4'(col - 1);
        m.top    = window_tap(pos, TAP_TOP) < self_code;
        m.bottom = window_tap(pos, TAP_BOTTOM) < self_code;
        m.left   = window_tap(pos, TAP_LEFT) < self_code;
        m.right  = window_tap(pos, TAP_RIGHT) < self_code;
        m.front  = window_tap(pos, TAP_FRONT) < self_code;
        m.back   = window_tap(pos, TAP_BACK) < self_code;
        m.last   = lay == GRID_EDGE && row == GRID_EDGE && col == GRID_EDGE;
        due_masks.push_back(m);
    endtask

    always @(posedge clk)
    begin
        face_mask_t want;
        face_mask_t got;
        if (!rst_n)
        begin
            next_cell_pos = 0;
            fail_count    = 0;
            due_masks.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_cell(code_t'(opacity_code), grid_start);
            if (out_valid && out_ready)
            begin
                got = {cell_x, cell_y, cell_z, face_top, face_bottom, face_left,
                       face_right, face_front, face_back, last_cell};
                if (due_masks.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing due: x=%0d y=%0d z=%0d",
                                 $realtime, got.x, got.y, got.z);
                    fail_count++;
                end
                else
                begin
                    want = due_masks.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: expected x=%0d y=%0d z=%0d tblrfb=%b last=%b",
                                     $realtime, want.x, want.y, want.z, want[6:1],
                                     want.last);
                            $display("%0t: got      x=%0d y=%0d z=%0d tblrfb=%b last=%b",
                                     $realtime, got.x, got.y, got.z, got[6:1],
                                     got.last);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending <= due_masks.size();
    end

endmodule

// ===== tb/sv/tb_voxel_face_visibility_unit.sv =====
`timescale 1ns / 100ps

module tb_voxel_face_visibility_unit;
    import vfv_pkg::*;

    // Longest run of cycles with no beat on either channel before giving up
    localparam int QUIET_LIMIT = 4000;
    // Cycles to linger after the last result, well past the three-stage pipe
    localparam int DRAIN_CYCLES = 16;
    // Cells of one grid streamed before the first judged cell completes
    localparam int LEAD_CELLS   = 2 * LAYER_CELLS + PAD_EDGE + 1;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] opacity_code;
    logic       grid_start;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] cell_z;
    logic       face_top;
    logic       face_bottom;
    logic       face_left;
    logic       face_right;
    logic       face_front;
    logic       face_back;
    logic       last_cell;

    int fail_count;
    int pending;

    // Percentage of cycles in which each side holds off
    int send_idle_pct;
    int take_idle_pct;

    voxel_face_visibility_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opacity_code (opacity_code),
        .grid_start   (grid_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .face_top     (face_top),
        .face_bottom  (face_bottom),
        .face_left    (face_left),
        .face_right   (face_right),
        .face_front   (face_front),
        .face_back    (face_back),
        .last_cell    (last_cell)
    );

    // The checker watches both channels from the side, predicting the face
    // mask of every judged cell and comparing it with what leaves the block.
    voxel_face_visibility_checker face_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opacity_code (opacity_code),
        .grid_start   (grid_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .face_top     (face_top),
        .face_bottom  (face_bottom),
        .face_left    (face_left),
        .face_right   (face_right),
        .face_front   (face_front),
        .face_back    (face_back),
        .last_cell    (last_cell),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: drop ready at random for the share of cycles set per phase
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Opacity mix: air, solid, a cluster of tiny codes so that equal
    // neighbours turn up often (a face needs a strictly lower neighbour),
    // and the full range.
    function automatic logic [7:0] pick_opacity();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one beat, idling first at random; return at the accepting edge
    // with valid still high so that the next beat can follow back to back.
    task automatic send_cell(logic [7:0] code, logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opacity_code <= code;
        grid_start   <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Well-formed stream: 'count' cells, flagged as a new grid if asked
    task automatic send_run(int count, logic first_start);
        for (int i = 0; i < count; i++)
            send_cell(pick_opacity(), first_start && i == 0);
    endtask

    // Noise: random cells with the odd stray grid start among them
    task automatic send_noise(int count);
        for (int i = 0; i < count; i++)
            send_cell(8'($urandom_range(255)), $urandom_range(63) == 0);
    endtask

    // Watchdog: end the run if neither channel moves a beat for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_voxel_face_visibility_unit: FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0] edge_codes [8];
        int         run_len;
        edge_codes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};

        // Hold every input at a known value through reset
        send_idle_pct = 0;
        take_idle_pct = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opacity_code  <= 8'h00;
        grid_start    <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: extreme and alternating codes, with grid starts
        // at the head, in the middle of the run and twice in a row
        for (int i = 0; i < 20; i++)
            send_cell(edge_codes[i % 8], i == 0 || i == 9 || i == 16 || i == 17);

        // Three idling phases: sender light and receiver heavy, then swapped,
        // then flat out. The first phase restarts mid-grid with a grid start
        // and streams just past the first judged cell; the later phases carry
        // on through the same grid so every phase sees judged cells.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 26;
                    take_idle_pct = 71;
                    run_len       = LEAD_CELLS + 24;
                end
                1:
                begin
                    send_idle_pct = 71;
                    take_idle_pct = 26;
                    run_len       = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                    run_len       = 30;
                end
            endcase
            send_run(run_len, phase == 0);
        end
        // Break the grid off with noise and stray grid starts
        send_noise(10);
        in_valid <= 1'b0;

        // Wait for every judged cell to come out, then let the pipe settle
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_voxel_face_visibility_unit: PASS");
        else
            $display("tb_voxel_face_visibility_unit: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vfv_pkg.sv
rtl/voxel_face_visibility_unit.sv
tb/sv/voxel_face_visibility_checker.sv
tb/sv/tb_voxel_face_visibility_unit.sv
